FILE: design/mesh_support_point_search_top_assert.svh
// Assertion macros for the support-point search block.
`ifndef MESH_SUPPORT_POINT_SEARCH_TOP_ASSERT_SVH
`define MESH_SUPPORT_POINT_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, reset-qualified.
`define MSPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset-qualified.
`define MSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/msps_pkg.sv
// Shared types, codes and helpers for the support-point search block.
package msps_pkg;

	// Vertex transaction, signed Q8.8 coordinates.
	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic signed [15:0] vertex_z;
		logic               last_vertex;
	} vertex_t;

	// Result transaction: Q20.16 point, Q32.24 dot.
	typedef struct packed {
		logic signed [35:0] point_x;
		logic signed [35:0] point_y;
		logic signed [35:0] point_z;
		logic signed [55:0] support_dot;
	} result_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ROW_X = 2'd0;
	localparam logic [1:0] CFG_ROW_Y = 2'd1;
	localparam logic [1:0] CFG_ROW_Z = 2'd2;
	localparam logic [1:0] CFG_DIR   = 2'd3;

	// MAC pass codes: three matrix rows, then the dot product.
	localparam logic [1:0] ROW_X   = 2'd0;
	localparam logic [1:0] ROW_Y   = 2'd1;
	localparam logic [1:0] ROW_Z   = 2'd2;
	localparam logic [1:0] ROW_DOT = 2'd3;

	// Term index within a pass.
	localparam logic [1:0] COL_FIRST = 2'd0;
	localparam logic [1:0] COL_MID   = 2'd1;
	localparam logic [1:0] COL_LAST  = 2'd2;

	// Controller to datapath.
	typedef struct packed {
		logic       capture;
		logic       mac;
		logic [1:0] row;
		logic [1:0] col;
		logic       decide;
		logic       emit;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic last;
		logic out_free;
	} sts_t;

	// Signed 16-bit lane k of a packed word.
	function automatic logic signed [15:0] lane16(input logic [63:0] w, input logic [1:0] k);
		lane16 = w[k*16 +: 16];
	endfunction

endpackage

FILE: design/msps_ctrl.sv
// Sequencer for the support-point search: accept, twelve MAC steps, decide, emit.
module msps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  msps_pkg::sts_t   sts,
	output msps_pkg::cmd_t   cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_MAC    = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [1:0] row_q;
	logic [1:0] row_d;
	logic [1:0] col_q;
	logic [1:0] col_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		col_d       = col_q;
		cmd         = '0;
		cmd.row     = row_q;
		cmd.col     = col_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					row_d       = msps_pkg::ROW_X;
					col_d       = msps_pkg::COL_FIRST;
					state_d     = ST_MAC;
				end
			end
			ST_MAC: begin
				cmd.mac = 1'b1;
				if (col_q == msps_pkg::COL_LAST) begin
					col_d = msps_pkg::COL_FIRST;
					if (row_q == msps_pkg::ROW_DOT) begin
						state_d = ST_DECIDE;
					end else begin
						row_d = row_q + 2'd1;
					end
				end else begin
					col_d = col_q + 2'd1;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = sts.last ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				// wait for the output register to drain
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= msps_pkg::ROW_X;
			col_q   <= msps_pkg::COL_FIRST;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
		end
	end

endmodule

FILE: design/msps_dp.sv
// Datapath: shared 36x16 MAC, world point and dot registers, running best, output register.
module msps_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  msps_pkg::cmd_t    cmd,
	output msps_pkg::sts_t    sts,
	input  msps_pkg::vertex_t in_data,
	input  logic [63:0]       row_x,
	input  logic [63:0]       row_y,
	input  logic [63:0]       row_z,
	input  logic [47:0]       dir,
	output logic              out_valid,
	input  logic              out_stall,
	output msps_pkg::result_t out_data
);

	msps_pkg::vertex_t  vtx_q;
	logic signed [35:0] wx_q, wy_q, wz_q;
	logic signed [55:0] acc_q;
	logic signed [55:0] dot_q;
	logic               have_best_q;
	logic signed [55:0] best_dot_q;
	logic signed [35:0] best_x_q, best_y_q, best_z_q;
	msps_pkg::result_t  out_q;
	logic               out_valid_q;

	logic signed [35:0] op_a;
	logic signed [15:0] op_b;
	logic [63:0]        coef_word;
	logic signed [51:0] prod;
	logic signed [55:0] base;
	logic signed [55:0] acc_next;
	logic signed [15:0] bias;
	logic               replace;

	// operand A: vertex lane during transform passes, world coordinate during the dot
	always_comb begin
		case (cmd.col)
			msps_pkg::COL_FIRST: op_a = (cmd.row == msps_pkg::ROW_DOT) ? wx_q
				: {{20{vtx_q.vertex_x[15]}}, vtx_q.vertex_x};
			msps_pkg::COL_MID:   op_a = (cmd.row == msps_pkg::ROW_DOT) ? wy_q
				: {{20{vtx_q.vertex_y[15]}}, vtx_q.vertex_y};
			msps_pkg::COL_LAST:  op_a = (cmd.row == msps_pkg::ROW_DOT) ? wz_q
				: {{20{vtx_q.vertex_z[15]}}, vtx_q.vertex_z};
			default:             op_a = '0;
		endcase
	end

	always_comb begin
		case (cmd.row)
			msps_pkg::ROW_X: coef_word = row_x;
			msps_pkg::ROW_Y: coef_word = row_y;
			msps_pkg::ROW_Z: coef_word = row_z;
			default:         coef_word = {16'd0, dir};
		endcase
	end

	assign op_b = msps_pkg::lane16(coef_word, cmd.col);
	assign bias = msps_pkg::lane16(coef_word, 2'd3);
	assign prod = op_a * op_b;

	// first term of a row pass starts from m3 * 1.0 (Q8.8 -> Q16.16); dot starts from 0
	always_comb begin
		if (cmd.col == msps_pkg::COL_FIRST) begin
			base = (cmd.row == msps_pkg::ROW_DOT) ? 56'sd0
				: {{32{bias[15]}}, bias, 8'd0};
		end else begin
			base = acc_q;
		end
	end

	assign acc_next = base + {{4{prod[51]}}, prod};
	assign replace  = !have_best_q || (dot_q > best_dot_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			vtx_q <= in_data;
		end
		if (cmd.mac) begin
			acc_q <= acc_next;
			if (cmd.col == msps_pkg::COL_LAST) begin
				case (cmd.row)
					msps_pkg::ROW_X: wx_q  <= acc_next[35:0];
					msps_pkg::ROW_Y: wy_q  <= acc_next[35:0];
					msps_pkg::ROW_Z: wz_q  <= acc_next[35:0];
					default:         dot_q <= acc_next;
				endcase
			end
		end
		if (cmd.decide && replace) begin
			best_dot_q <= dot_q;
			best_x_q   <= wx_q;
			best_y_q   <= wy_q;
			best_z_q   <= wz_q;
		end
		if (cmd.emit) begin
			out_q.point_x     <= best_x_q;
			out_q.point_y     <= best_y_q;
			out_q.point_z     <= best_z_q;
			out_q.support_dot <= best_dot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				have_best_q <= 1'b0;
			end else if (cmd.decide) begin
				have_best_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.last     = vtx_q.last_vertex;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

FILE: design/mesh_support_point_search_top.sv
// Top level of the mesh support-point search block: configuration registers and core.
// Streams model-space vertices (signed Q8.8), transforms each by a 3x4 world matrix,
// dots the world point with a search direction and keeps the point with the greatest
// dot (earliest wins ties). The vertex flagged last_vertex releases one result
// transaction: the kept Q20.16 point and its Q32.24 dot, after which the search
// restarts. One multiply-accumulate unit is shared by all twelve products, so a vertex
// occupies the block through accept, 12 MAC steps and compare, and a last vertex also
// waits to load the output register while an earlier result is still held there;
// in_stall is high for all of it but the accept cycle.
// The output register lets the next query start while a result waits to be taken.
// Configuration writes are always ready and take effect for the next vertex; write
// only while idle.
`include "mesh_support_point_search_top_assert.svh"

module mesh_support_point_search_top (
	input  logic              clk,
	input  logic              arst_n,
	// vertex transactions
	input  logic              in_valid,
	output logic              in_stall,
	input  msps_pkg::vertex_t in_data,
	// result transactions
	output logic              out_valid,
	input  logic              out_stall,
	output msps_pkg::result_t out_data,
	// configuration writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_data
);

	// Matrix rows: four Q8.8 coefficients each, m0 in the low lane, m3 is the offset.
	logic [63:0] row_x_q;
	logic [63:0] row_y_q;
	logic [63:0] row_z_q;
	// Direction: x, y, z Q8.8 lanes, x low.
	logic [47:0] dir_q;

	msps_pkg::cmd_t cmd;
	msps_pkg::sts_t sts;

	// Register file never back-pressures.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q <= '0;
			row_y_q <= '0;
			row_z_q <= '0;
			dir_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				msps_pkg::CFG_ROW_X: row_x_q <= cfg_data;
				msps_pkg::CFG_ROW_Y: row_y_q <= cfg_data;
				msps_pkg::CFG_ROW_Z: row_z_q <= cfg_data;
				msps_pkg::CFG_DIR:   dir_q   <= cfg_data[47:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: walks rows x, y, z then the dot, three terms each.
	msps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// MAC, running best and output register.
	msps_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.row_x     (row_x_q),
		.row_y     (row_y_q),
		.row_z     (row_z_q),
		.dir       (dir_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// An accepted vertex keeps the block busy on the next cycle.
	`MSPS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
	// Result appears only from an emit command.
	`MSPS_ASSERT_NOW(a_out_from_emit, $rose(out_valid), $past(cmd.emit), "result without emit")
	// Emit never overwrites a result still waiting.
	`MSPS_ASSERT_NOW(a_emit_slot_free, cmd.emit, !out_valid || !out_stall, "emit over held result")
	// Commands are mutually exclusive.
	`MSPS_ASSERT_NOW(a_cmd_exclusive, 1'b1, $onehot0({cmd.capture, cmd.mac, cmd.decide, cmd.emit}),
		"overlapping commands")

endmodule

FILE: test/tb.sv
// Self-checking testbench for mesh_support_point_search_top: directed, then random traffic.
`timescale 1ns / 100ps

// Running support-point prediction and the queue of pending result transactions.
class support_scoreboard;
	logic [63:0]       row_x, row_y, row_z;
	logic [47:0]       dir;
	bit                have_best;
	longint            best_x, best_y, best_z, best_dot;
	msps_pkg::result_t pending_q[$];
	int                errors;

	function new();
		row_x = '0;
		row_y = '0;
		row_z = '0;
		dir = '0;
		errors = 0;
		clear_best();
	endfunction

	function void clear_best();
		have_best = 1'b0;
		best_x = 0;
		best_y = 0;
		best_z = 0;
		best_dot = 0;
	endfunction

	function longint sx16(logic [15:0] a);
		logic signed [15:0] s;
		s = a;
		return s;
	endfunction

	// Q8.8 row times (vx, vy, vz, 1.0) gives Q20.16
	function longint world(logic [63:0] row, longint vx, longint vy, longint vz);
		return sx16(row[15:0]) * vx + sx16(row[31:16]) * vy + sx16(row[47:32]) * vz
			+ sx16(row[63:48]) * 256;
	endfunction

	function void write_reg(logic [1:0] idx, logic [63:0] value);
		case (idx)
			msps_pkg::CFG_ROW_X: row_x = value;
			msps_pkg::CFG_ROW_Y: row_y = value;
			msps_pkg::CFG_ROW_Z: row_z = value;
			msps_pkg::CFG_DIR:   dir = value[47:0];
			default:   ;
		endcase
	endfunction

	function void note_vertex(msps_pkg::vertex_t v);
		longint            vx, vy, vz, wx, wy, wz, d;
		msps_pkg::result_t r;
		vx = sx16(v.vertex_x);
		vy = sx16(v.vertex_y);
		vz = sx16(v.vertex_z);
		wx = world(row_x, vx, vy, vz);
		wy = world(row_y, vx, vy, vz);
		wz = world(row_z, vx, vy, vz);
		d = wx * sx16(dir[15:0]) + wy * sx16(dir[31:16]) + wz * sx16(dir[47:32]);
		// first vertex of a query always wins, later ones only on a strictly greater dot
		if (!have_best || d > best_dot) begin
			have_best = 1'b1;
			best_x = wx;
			best_y = wy;
			best_z = wz;
			best_dot = d;
		end
		if (v.last_vertex) begin
			r.point_x = best_x[35:0];
			r.point_y = best_y[35:0];
			r.point_z = best_z[35:0];
			r.support_dot = best_dot[55:0];
			pending_q.push_back(r);
			clear_best();
		end
	endfunction

	function void check_field(string name, logic [55:0] want, logic [55:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_result(msps_pkg::result_t got);
		msps_pkg::result_t want;
		if (pending_q.size() == 0) begin
			$display("%0t: unexpected result transaction %h", $time, got);
			errors++;
			return;
		end
		want = pending_q.pop_front();
		check_field("point_x", 56'(want.point_x), 56'(got.point_x));
		check_field("point_y", 56'(want.point_y), 56'(got.point_y));
		check_field("point_z", 56'(want.point_z), 56'(got.point_z));
		check_field("support_dot", want.support_dot, got.support_dot);
	endfunction

	function int pending();
		return pending_q.size();
	endfunction
endclass

module tb;

	// Run limit in cycles: ample for ~575 vertices with their busy time, input gaps
	// and result stalls.
	localparam int LIMIT = 250000;
	// Idle time after the last result before touching config: one vertex may still
	// be busy after acceptance when no result is pending.
	localparam int SETTLE = 32;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 92;
	// Past this many random vertices neither side idles.
	localparam int CALM_AFTER = 480;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	msps_pkg::vertex_t in_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	msps_pkg::result_t out_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = msps_pkg::CFG_ROW_X;
	logic [63:0]       cfg_data = '0;

	support_scoreboard sb = new();

	int                cycle_count = 0;
	int                rand_sent = 0;
	int                query_left = 0;
	int                gap_odds = 4;
	int                stall_odds = 6;
	int                stall_left = 0;
	bit                calm = 1'b0;
	msps_pkg::vertex_t prev_vertex = '0;

	mesh_support_point_search_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Monitors: sample handshakes at the edge, before any NBA updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.note_vertex(in_data);
			if (out_valid && !out_stall)
				sb.check_result(out_data);
		end
	end

	// Result side back-pressure: random bursts of stalled cycles.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 11);
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic msps_pkg::vertex_t vtx(logic [15:0] x, logic [15:0] y,
			logic [15:0] z, logic last);
		msps_pkg::vertex_t v;
		v.vertex_x = x;
		v.vertex_y = y;
		v.vertex_z = z;
		v.last_vertex = last;
		return v;
	endfunction

	// Coordinates lean toward the extremes and small values so both sign and
	// magnitude corners show up often.
	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'h0000;
			3:       return 16'($urandom_range(0, 511)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] rand_word();
		logic [63:0] w;
		case ($urandom_range(0, 5))
			0: w = '0;
			1: w = {4{16'h8000}};
			2: w = {4{16'h7fff}};
			3: begin
				for (int k = 0; k < 4; k++)
					w[16*k +: 16] = 16'($urandom_range(0, 1023)) - 16'd512;
			end
			default: w = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [63:0] rx, input logic [63:0] ry,
			input logic [63:0] rz, input logic [63:0] dv);
		write_reg(msps_pkg::CFG_ROW_X, rx);
		write_reg(msps_pkg::CFG_ROW_Y, ry);
		write_reg(msps_pkg::CFG_ROW_Z, rz);
		write_reg(msps_pkg::CFG_DIR, dv);
	endtask

	// Valid stays up after acceptance; the next call just swaps the payload.
	task automatic send_vertex(input msps_pkg::vertex_t v);
		in_valid <= 1'b1;
		in_data <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic maybe_pause();
		if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Sender holds off until every pending result is back, then lets the core settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Mostly short queries, now and then a long one; repeats of the previous
	// vertex make ties. A query may straddle a phase boundary, so config changes
	// also land mid-query.
	task automatic run_random(input int count);
		msps_pkg::vertex_t v;
		for (int n = 0; n < count; n++) begin
			if (query_left == 0)
				query_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
					: $urandom_range(1, 6);
			if ($urandom_range(0, 7) == 0)
				v = prev_vertex;
			else
				v = vtx(rand_coord(), rand_coord(), rand_coord(), 1'b0);
			query_left--;
			v.last_vertex = (query_left == 0);
			prev_vertex = v;
			if (rand_sent >= CALM_AFTER)
				calm = 1'b1;
			maybe_pause();
			send_vertex(v);
			rand_sent++;
		end
	endtask

	initial begin
		int bad;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: x' = vx + 1.0, y' = vy, z' = vz; direction +x.
		program_regs({16'h0100, 16'h0000, 16'h0000, 16'h0100},
			{16'h0000, 16'h0000, 16'h0100, 16'h0000},
			{16'h0000, 16'h0100, 16'h0000, 16'h0000},
			{16'h0000, 16'h0000, 16'h0000, 16'h0100});
		// single-vertex query
		send_vertex(vtx(16'h8000, 16'h7fff, 16'h0001, 1'b1));
		// no dot is positive; first vertex still taken, equal dot does not replace
		send_vertex(vtx(16'hff00, 16'h0010, 16'h0000, 1'b0));
		send_vertex(vtx(16'hff00, 16'h0020, 16'h0000, 1'b0));
		send_vertex(vtx(16'hfe00, 16'h0000, 16'h0000, 1'b1));
		// later, strictly greater dot replaces
		send_vertex(vtx(16'h0000, 16'h0005, 16'h0000, 1'b0));
		send_vertex(vtx(16'h0100, 16'h0006, 16'h0000, 1'b0));
		send_vertex(vtx(16'h7fff, 16'h8000, 16'h7fff, 1'b1));
		drain();

		// Most negative everywhere; junk above the direction's 48 bits is dropped.
		program_regs({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
			{16'hffff, {3{16'h8000}}});
		send_vertex(vtx(16'h8000, 16'h8000, 16'h8000, 1'b1));
		send_vertex(vtx(16'h7fff, 16'h7fff, 16'h7fff, 1'b1));
		send_vertex(vtx(16'h0000, 16'h0000, 16'h0000, 1'b1));
		send_vertex(vtx(16'h8000, 16'h7fff, 16'h8000, 1'b0));
		send_vertex(vtx(16'h7fff, 16'h8000, 16'h7fff, 1'b1));
		drain();

		// Most positive everywhere.
		program_regs({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}});
		send_vertex(vtx(16'h8000, 16'h8000, 16'h8000, 1'b1));
		send_vertex(vtx(16'h7fff, 16'h7fff, 16'h7fff, 1'b1));
		send_vertex(vtx(16'h0000, 16'h0000, 16'h0000, 1'b1));
		send_vertex(vtx(16'h8000, 16'h7fff, 16'h8000, 1'b0));
		send_vertex(vtx(16'h7fff, 16'h8000, 16'h7fff, 1'b1));
		// Mid-query direction flip: kept point keeps its old dot, the new vertex
		// dots negative under the new direction and must lose.
		send_vertex(vtx(16'h0100, 16'h0200, 16'h0300, 1'b0));
		drain();
		write_reg(msps_pkg::CFG_DIR, {16'h0000, {3{16'h8000}}});
		send_vertex(vtx(16'h0100, 16'h0200, 16'h0300, 1'b1));
		drain();

		// Random phases, each with its own config and idling mix.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				program_regs('0, '0, '0, '0);
			else
				program_regs(rand_word(), rand_word(), rand_word(), rand_word());
			gap_odds = (p % 3 == 1) ? 0 : $urandom_range(2, 8);
			stall_odds = (p % 3 == 2) ? 0 : $urandom_range(2, 10);
			run_random(PHASE_ITEMS);
			drain();
		end

		bad = sb.errors + sb.pending();
		if (bad == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
